[design/arls_pkg.sv]
// ----------------------------------------------------------------------------
// arls_pkg
// Shared types and constants of the adaptive-rate level smoother.
// ----------------------------------------------------------------------------
package arls_pkg;

  localparam int ROWS_DEF    = 8;
  localparam int LANES_DEF   = 32;
  localparam int QUEUE_DEPTH = 4;

  // Q2.14 limits of the rate curve
  localparam logic signed [16:0] TARGET_FLOOR = -17'sd15124;
  localparam logic signed [17:0] DEAD_ZONE    = 18'sd252;
  localparam logic signed [17:0] CAP_LIMIT    = 18'sd1260;
  localparam logic [9:0]         CAP_VALUE    = 10'd1008;

  typedef enum logic [2:0] {
    CFG_LEVEL_OFFSET   = 3'd0,
    CFG_FALL_CONSTANT  = 3'd1,
    CFG_FALL_LINEAR    = 3'd2,
    CFG_FALL_QUADRATIC = 3'd3,
    CFG_RISE_CONSTANT  = 3'd4,
    CFG_RISE_LINEAR    = 3'd5,
    CFG_RISE_QUADRATIC = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] level_offset;
    logic signed [19:0] fall_constant;
    logic signed [19:0] fall_linear;
    logic signed [19:0] fall_quadratic;
    logic signed [19:0] rise_constant;
    logic signed [19:0] rise_linear;
    logic signed [19:0] rise_quadratic;
  } cfg_t;

  // Classified item as it waits in the queue
  typedef struct packed {
    logic               in_range;
    logic signed [16:0] target;
  } item_t;

endpackage

[design/arls_front.sv]
// ----------------------------------------------------------------------------
// arls_front
// Classifies an incoming sample: store address, range check, clamped target.
// ----------------------------------------------------------------------------
module arls_front #(
  parameter int ROWS  = arls_pkg::ROWS_DEF,
  parameter int LANES = arls_pkg::LANES_DEF,
  parameter int AW    = 8
) (
  input  logic [2:0]          row_index,
  input  logic [4:0]          lane_index,
  input  logic signed [15:0]  sample_level,
  input  logic signed [15:0]  level_offset,
  output logic [AW-1:0]       addr,
  output arls_pkg::item_t     item
);

  logic [15:0]        addr_full;
  logic signed [16:0] sum;

  always_comb begin
    addr_full = 16'(row_index) * 16'(LANES) + 16'(lane_index);
    addr      = addr_full[AW-1:0];
    item.in_range = (32'(row_index) < 32'(ROWS)) && (32'(lane_index) < 32'(LANES));
    sum = {sample_level[15], sample_level} + {level_offset[15], level_offset};
    item.target = (sum < arls_pkg::TARGET_FLOOR) ? arls_pkg::TARGET_FLOOR : sum;
  end

endmodule

[design/arls_queue.sv]
// ----------------------------------------------------------------------------
// arls_queue
// Short FIFO between the classifying front and the update pipeline.
// ----------------------------------------------------------------------------
module arls_queue #(
  parameter int W     = 8,
  parameter int DEPTH = arls_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(DEPTH));

endmodule

[design/arls_back.sv]
// ----------------------------------------------------------------------------
// arls_back
// Level store and seven-stage update pipeline with output register.
// ----------------------------------------------------------------------------
module arls_back #(
  parameter int ROWS  = arls_pkg::ROWS_DEF,
  parameter int LANES = arls_pkg::LANES_DEF,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  arls_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  logic [AW-1:0]      q_addr,
  input  arls_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               clr_busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_level
);

  localparam int DEPTH = ROWS * LANES;
  localparam int NST   = 7;

  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rd_r;

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // per-stage tags
  logic          v_r   [1:NST];
  logic          inr_r [1:NST];
  logic [AW-1:0] a_r   [1:NST];

  logic adv, hazard, issue;

  // stage payloads
  logic signed [16:0] tgt1_r;
  logic signed [15:0] old2_r, old3_r, old4_r, old5_r, old6_r, old7_r;
  logic signed [17:0] diff2_r, diff3_r, diff4_r, diff5_r, diff6_r;
  logic [9:0]         x2_r;
  logic               neg2_r;
  logic signed [19:0] cst3_r, quad3_r, quad4_r;
  logic signed [32:0] p1_3_r;
  logic [27:0]        sqraw3_r;
  logic signed [21:0] part4_r, part5_r;
  logic [14:0]        sq4_r;
  logic signed [35:0] p2_5_r;
  logic signed [22:0] coeff6_r;
  logic signed [40:0] prod7_r;
  logic               out_valid_r;
  logic signed [15:0] out_level_r;

  // stage combinational results
  logic signed [17:0] old1, diff1, mag1;
  logic [9:0]         x1;
  logic signed [19:0] cst2, lin2, quad2;
  logic signed [32:0] p1_2;
  logic [13:0]        x16;
  logic [27:0]        sqraw2;
  logic signed [33:0] p1_rnd;
  logic signed [21:0] part3;
  logic [28:0]        sq_rnd;
  logic signed [35:0] p2_4;
  logic signed [36:0] p2_rnd;
  logic signed [22:0] coeff5;
  logic signed [40:0] prod6;
  logic signed [41:0] prod_rnd;
  logic signed [42:0] lvl7;
  logic signed [15:0] lvl_sat;

  assign adv = !out_valid_r || !out_stall;

  // Hold the head while any in-flight item still owes the same entry a write.
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= NST; k++) begin
      if (v_r[k] && inr_r[k] && (a_r[k] == q_addr)) begin
        hazard = 1'b1;
      end
    end
    hazard = hazard && q_item.in_range;
  end

  assign issue = adv && !q_empty && !hazard && !clr_busy_r;
  assign q_pop = issue;

  always_comb begin
    old1  = inr_r[1] ? 18'(rd_r) : '0;
    diff1 = 18'(tgt1_r) - old1;
    mag1  = diff1[17] ? -diff1 : diff1;
    if (mag1 > arls_pkg::CAP_LIMIT) begin
      x1 = arls_pkg::CAP_VALUE;
    end else if (mag1 < arls_pkg::DEAD_ZONE) begin
      x1 = '0;
    end else begin
      x1 = 10'(mag1 - arls_pkg::DEAD_ZONE);
    end

    cst2   = neg2_r ? cfg.fall_constant  : cfg.rise_constant;
    lin2   = neg2_r ? cfg.fall_linear    : cfg.rise_linear;
    quad2  = neg2_r ? cfg.fall_quadratic : cfg.rise_quadratic;
    p1_2   = 33'(lin2) * 33'($signed({1'b0, x2_r, 2'b00}));
    x16    = {x2_r, 4'b0000};
    sqraw2 = 28'(x16) * 28'(x16);

    p1_rnd = (34'(p1_3_r) + 34'sd8192) >>> 14;
    part3  = 22'(cst3_r) + 22'(p1_rnd);
    sq_rnd = (29'(sqraw3_r) + 29'd8192) >> 14;

    p2_4 = 36'(quad4_r) * 36'($signed({1'b0, sq4_r}));

    p2_rnd = (37'(p2_5_r) + 37'sd8192) >>> 14;
    coeff5 = 23'(part5_r) + 23'(p2_rnd);

    prod6 = 41'(coeff6_r) * 41'(diff6_r);

    prod_rnd = (42'(prod7_r) + 42'sd8192) >>> 14;
    lvl7     = 43'(old7_r) + 43'(prod_rnd);
    if (lvl7 > 43'sd32767) begin
      lvl_sat = 16'sh7fff;
    end else if (lvl7 < -43'sd32768) begin
      lvl_sat = -16'sd32768;
    end else begin
      lvl_sat = 16'(lvl7);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      for (int k = 1; k <= NST; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (adv) begin
        v_r[1] <= issue;
        for (int k = 2; k <= NST; k++) begin
          v_r[k] <= v_r[k-1];
        end
        out_valid_r <= v_r[NST];
      end
    end
  end

  // level store
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (adv && v_r[NST] && inr_r[NST]) begin
      mem[a_r[NST]] <= lvl_sat;
    end
    if (issue) begin
      rd_r <= mem[q_addr];
    end
  end

  // datapath, advances with the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      inr_r[1] <= q_item.in_range;
      a_r[1]   <= q_addr;
      for (int k = 2; k <= NST; k++) begin
        inr_r[k] <= inr_r[k-1];
        a_r[k]   <= a_r[k-1];
      end
      tgt1_r <= q_item.target;

      old2_r  <= 16'(old1);
      diff2_r <= diff1;
      x2_r    <= x1;
      neg2_r  <= diff1[17];

      old3_r   <= old2_r;
      diff3_r  <= diff2_r;
      cst3_r   <= cst2;
      quad3_r  <= quad2;
      p1_3_r   <= p1_2;
      sqraw3_r <= sqraw2;

      old4_r  <= old3_r;
      diff4_r <= diff3_r;
      part4_r <= part3;
      quad4_r <= quad3_r;
      sq4_r   <= 15'(sq_rnd);

      old5_r  <= old4_r;
      diff5_r <= diff4_r;
      part5_r <= part4_r;
      p2_5_r  <= p2_4;

      old6_r   <= old5_r;
      diff6_r  <= diff5_r;
      coeff6_r <= coeff5;

      old7_r  <= old6_r;
      prod7_r <= prod6;

      out_level_r <= lvl_sat;
    end
  end

  assign clr_busy  = clr_busy_r;
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

endmodule

[design/adaptive_rate_level_smoother.sv]
// An accepted input passes through the queue, the update pipeline and the
// output register. Throughput: one item per cycle while the output is not
// stalled; an item whose lane is still in the seven-stage update pipeline
// waits until that lane's write lands. Reset: configuration clears to zero;
// the level store is then cleared over all ROWS*LANES entries, input stalled.
// ----------------------------------------------------------------------------
// adaptive_rate_level_smoother
// Per-lane level smoother with a step-dependent attack/release rate.
// ----------------------------------------------------------------------------
module adaptive_rate_level_smoother #(
  parameter int ROWS  = arls_pkg::ROWS_DEF,
  parameter int LANES = arls_pkg::LANES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_row_index,
  input  logic [4:0]         in_lane_index,
  input  logic signed [15:0] in_sample_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_smoothed_level,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  localparam int DEPTH = ROWS * LANES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = AW + $bits(arls_pkg::item_t);

  arls_pkg::cfg_t  cfg_r;
  logic [AW-1:0]   f_addr, q_addr;
  arls_pkg::item_t f_item, q_item;
  logic [QW-1:0]   q_head;
  logic            q_empty, q_full, q_pop, push, clr_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (arls_pkg::cfg_idx_t'(cfg_index))
        arls_pkg::CFG_LEVEL_OFFSET:   cfg_r.level_offset   <= cfg_data[15:0];
        arls_pkg::CFG_FALL_CONSTANT:  cfg_r.fall_constant  <= cfg_data;
        arls_pkg::CFG_FALL_LINEAR:    cfg_r.fall_linear    <= cfg_data;
        arls_pkg::CFG_FALL_QUADRATIC: cfg_r.fall_quadratic <= cfg_data;
        arls_pkg::CFG_RISE_CONSTANT:  cfg_r.rise_constant  <= cfg_data;
        arls_pkg::CFG_RISE_LINEAR:    cfg_r.rise_linear    <= cfg_data;
        arls_pkg::CFG_RISE_QUADRATIC: cfg_r.rise_quadratic <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full || clr_busy;
  assign push     = in_valid && !in_stall;

  arls_front #(.ROWS(ROWS), .LANES(LANES), .AW(AW)) u_front (
    .row_index    (in_row_index),
    .lane_index   (in_lane_index),
    .sample_level (in_sample_level),
    .level_offset (cfg_r.level_offset),
    .addr         (f_addr),
    .item         (f_item)
  );

  arls_queue #(.W(QW), .DEPTH(arls_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_addr, f_item}),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign q_addr = q_head[QW-1 -: AW];
  assign q_item = arls_pkg::item_t'(q_head[$bits(arls_pkg::item_t)-1:0]);

  arls_back #(.ROWS(ROWS), .LANES(LANES), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_addr    (q_addr),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_level (out_smoothed_level)
  );

endmodule

[sim/tb_adaptive_rate_level_smoother.sv]
// ----------------------------------------------------------------------------
// tb_adaptive_rate_level_smoother
// Streams lane samples through the level smoother, predicts each updated level
// and compares results in order, across several coefficient settings and
// idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_adaptive_rate_level_smoother;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic [2:0]         row;
    logic [4:0]         lane;
    logic signed [15:0] sample;
  } sample_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_row_index = '0;
  logic [4:0]         in_lane_index = '0;
  logic signed [15:0] in_sample_level = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_smoothed_level;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [19:0]        cfg_data = '0;

  adaptive_rate_level_smoother u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_row_index(in_row_index), .in_lane_index(in_lane_index),
    .in_sample_level(in_sample_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_smoothed_level(out_smoothed_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  longint             pred_offset;
  longint             pred_coef[6];
  logic signed [15:0] pred_levels[256];

  sample_item_t       pending_samples[$];
  logic signed [15:0] expected_levels[$];
  int                 mismatch_count = 0;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_off_cycles = 0;
  int                 quiet_cycles = 0;

  function automatic longint round_q14(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic logic signed [15:0] smooth_level(sample_item_t it);
    longint old, target, diff, mag, x, coeff, sq, lvl;
    int     base;
    old = pred_levels[{it.row, it.lane}];
    target = longint'(it.sample) + pred_offset;
    if (target < -15124) target = -15124;
    diff = target - old;
    base = (diff < 0) ? 0 : 3;
    mag = (diff < 0) ? -diff : diff;
    if (mag > 1260) x = 1008;
    else if (mag < 252) x = 0;
    else x = mag - 252;
    coeff = pred_coef[base] + round_q14(pred_coef[base+1] * (4 * x));
    sq = round_q14((16 * x) * (16 * x));
    coeff += round_q14(pred_coef[base+2] * sq);
    lvl = old + round_q14(coeff * diff);
    if (lvl > 32767) lvl = 32767;
    if (lvl < -32768) lvl = -32768;
    pred_levels[{it.row, it.lane}] = 16'(lvl);
    return 16'(lvl);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  logic in_accepted;
  always @(posedge clk) in_accepted <= in_valid && !in_stall && rst_n;

  // driver
  always @(negedge clk) begin
    sample_item_t it;
    if (rst_n) begin
      if (in_accepted || !in_valid) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_samples.pop_front();
          expected_levels.push_back(smooth_level(it));
          in_row_index <= it.row;
          in_lane_index <= it.lane;
          in_sample_level <= it.sample;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off while one is requested
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0)
          report_mismatch("unexpected result", out_smoothed_level, 0);
        else if (out_smoothed_level !== expected_levels[0])
          report_mismatch("smoothed_level", out_smoothed_level, expected_levels[0]);
        if (expected_levels.size() > 0) void'(expected_levels.pop_front());
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready)
          || hold_off_cycles > 0)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout waiting for transfer");
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic write_reg(arls_pkg::cfg_idx_t idx, logic [19:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == arls_pkg::CFG_LEVEL_OFFSET) pred_offset = longint'($signed(value[15:0]));
    else pred_coef[idx - 1] = longint'($signed(value));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || expected_levels.size() > 0 || in_valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(logic [15:0] offs, logic [19:0] c[6]);
    write_reg(arls_pkg::CFG_LEVEL_OFFSET, {4'b0, offs});
    for (int i = 0; i < 6; i++) write_reg(arls_pkg::cfg_idx_t'(i + 1), c[i]);
  endtask

  function automatic sample_item_t rand_sample(bit hot_lanes);
    sample_item_t it;
    it.row = hot_lanes ? 3'($urandom_range(1)) : 3'($urandom);
    it.lane = hot_lanes ? 5'($urandom_range(3)) : 5'($urandom);
    case ($urandom_range(5))
      0: it.sample = 16'sh7fff;
      1: it.sample = -16'sh8000;
      2: it.sample = 16'($urandom_range(2000)) - 16'sd1000;
      default: it.sample = 16'($urandom);
    endcase
    return it;
  endfunction

  initial begin
    logic [19:0] coefs[6];
    sample_item_t it;
    pred_offset = 0;
    foreach (pred_coef[i]) pred_coef[i] = 0;
    foreach (pred_levels[i]) pred_levels[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes and band edges with moderate rates
    coefs = '{20'h01000, 20'h00800, 20'h00100, 20'h02000, 20'h01000, 20'h00200};
    load_settings(16'h0000, coefs);
    begin
      logic signed [15:0] dir[];
      dir = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd251,
        16'sd252, 16'sd253, 16'sd1260, 16'sd1261, 16'sd1512, -16'sd15124,
        -16'sd15125, 16'sd0, -16'sd300, 16'sd5000};
      foreach (dir[i]) begin
        it.row = 3'(i); it.lane = 5'(31 - i); it.sample = dir[i];
        pending_samples.push_back(it);
        it.row = 3'd7; it.lane = 5'd31;
        pending_samples.push_back(it);
      end
    end
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: coefs = '{20'h7ffff, 20'h7ffff, 20'h7ffff, 20'h80000, 20'h80000, 20'h80000};
        1: coefs = '{20'h80000, 20'h80000, 20'h80000, 20'h7ffff, 20'h7ffff, 20'h7ffff};
        2: coefs = '{20'h0, 20'h0, 20'h0, 20'h0, 20'h0, 20'h0};
        default: foreach (coefs[i]) coefs[i] = ($urandom_range(1)) ? 20'($urandom)
                                          : 20'($urandom_range(16384)) - 20'd4096;
      endcase
      load_settings(phase == 0 ? 16'h7fff : phase == 1 ? 16'h8000 : 16'($urandom), coefs);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      for (int n = 0; n < 160; n++)
        pending_samples.push_back(rand_sample($urandom_range(3) == 0));
      if (phase == 4) begin
        send_idle_pct = 0;
        hold_off_cycles = 200;
      end
      // sender pauses here until everything has come back
      wait_drained();
    end

    if (mismatch_count == 0 && expected_levels.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

[adaptive_rate_level_smoother.f]
design/arls_pkg.sv
design/arls_front.sv
design/arls_queue.sv
design/arls_back.sv
design/adaptive_rate_level_smoother.sv
sim/tb_adaptive_rate_level_smoother.sv
